>>> design/sat_pkg.sv
// Package for the sector allocation table: request codes, result word constants,
// the sequencer state type and the result record.
// It depends on nothing; every other design file refers to it by scoped names.
package sat_pkg;

    localparam int WORD_W   = 32;
    localparam int SECTOR_W = 12;
    localparam int COUNT_W  = 6;
    localparam int CFG_W    = 13;
    localparam int REQ_W    = 2;

    // The reserved sector count is the sector total divided by 128.
    localparam int RESV_SHIFT = 7;

    localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;

    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_UPDATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

    localparam logic signed [WORD_W-1:0] WORD_RESERVED = 32'sd2;
    localparam logic signed [WORD_W-1:0] WORD_INVALID  = 32'sd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_QWAIT,
        ST_SCAN,
        ST_SCHK
    } sat_state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] status_word;
        logic [SECTOR_W-1:0]      found_sector;
        logic                     ok;
        logic                     last;
    } sat_result_t;

endpackage

>>> design/sat_mem.sv
// Status table storage: one write port and one read port with registered read data.
// It depends on sat_pkg for the word width; the sequencer drives both ports.
module sat_mem #(
    parameter int MAX_SECTORS = 4096,
    parameter int ADDR_W      = 12
) (
    input  logic                            clk,
    input  logic                            we,
    input  logic [ADDR_W-1:0]               waddr,
    input  logic [sat_pkg::WORD_W-1:0]      wdata,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               raddr,
    output logic [sat_pkg::WORD_W-1:0]      rdata
);

    logic [sat_pkg::WORD_W-1:0] mem [MAX_SECTORS];
    logic [sat_pkg::WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/sat_seq.sv
// Sequencer of the sector allocation table: clearing pass, query, update and the
// free sector scan, all through the write and read ports of the status table.
// It depends on sat_pkg and drives the ports of sat_mem.
module sat_seq #(
    parameter int MAX_SECTORS = 4096,
    parameter int MAX_REQUEST = 32,
    parameter int ADDR_W      = 12,
    parameter int TW          = 13
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [sat_pkg::CFG_W-1:0]           total_cfg,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sat_pkg::REQ_W-1:0]           req_type,
    input  logic [sat_pkg::SECTOR_W-1:0]        sector,
    input  logic signed [sat_pkg::WORD_W-1:0]   new_value,
    input  logic [sat_pkg::COUNT_W-1:0]         wanted,
    input  logic                                out_free,
    output logic                                emit,
    output sat_pkg::sat_result_t                result,
    output logic                                mem_we,
    output logic [ADDR_W-1:0]                   mem_waddr,
    output logic [sat_pkg::WORD_W-1:0]          mem_wdata,
    output logic                                mem_rd_en,
    output logic [ADDR_W-1:0]                   mem_raddr,
    input  logic [sat_pkg::WORD_W-1:0]          mem_rdata
);

    localparam logic [TW-1:0]                   MAX_T   = TW'(MAX_SECTORS);
    localparam logic [ADDR_W-1:0]               CLR_END = ADDR_W'(MAX_SECTORS - 1);
    localparam logic [sat_pkg::COUNT_W-1:0]     REQ_MAX = sat_pkg::COUNT_W'(MAX_REQUEST);

    sat_pkg::sat_state_t state_reg, state_next;

    logic [sat_pkg::REQ_W-1:0]          req_reg;
    logic [TW-1:0]                      sector_reg;
    logic [sat_pkg::WORD_W-1:0]         value_reg;
    logic [sat_pkg::COUNT_W-1:0]        wanted_reg;
    logic [TW-1:0]                      off_reg, off_next;
    logic [sat_pkg::COUNT_W-1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0]                  clr_reg, clr_next;

    logic [TW-1:0]                      total_eff;
    logic [TW-1:0]                      resv;
    logic [TW-1:0]                      data_idx;
    logic [TW-1:0]                      scan_sector;
    logic                               in_resv;
    logic                               out_rng;
    logic                               data_ok;
    logic                               scan_end;
    logic                               bad_want;
    logic                               entry_free;
    logic [sat_pkg::COUNT_W-1:0]        cnt_inc;
    logic                               hit_last;
    logic                               accept;

    assign total_eff   = (TW'(total_cfg) > MAX_T) ? MAX_T : TW'(total_cfg);
    assign resv        = total_eff >> sat_pkg::RESV_SHIFT;
    assign in_resv     = sector_reg < resv;
    assign out_rng     = sector_reg >= total_eff;
    assign data_ok     = !in_resv && !out_rng;
    assign data_idx    = sector_reg - resv;
    assign scan_sector = resv + off_reg;
    assign scan_end    = scan_sector >= total_eff;
    assign bad_want    = (wanted_reg == '0) || (wanted_reg > REQ_MAX);
    assign entry_free  = mem_rdata == '0;
    assign cnt_inc     = cnt_reg + 1'b1;
    assign hit_last    = cnt_inc == wanted_reg;
    assign accept      = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sat_pkg::ST_CLEAR;
            off_reg   <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            off_reg   <= off_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= req_type;
            sector_reg <= TW'(sector);
            value_reg  <= new_value;
            wanted_reg <= wanted;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sat_pkg::ST_CLEAR:
            begin
                if (clr_reg == CLR_END)
                begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            sat_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sat_pkg::ST_EXEC;
                end
            end
            sat_pkg::ST_EXEC:
            begin
                if (req_reg == sat_pkg::REQ_QUERY && data_ok)
                begin
                    state_next = sat_pkg::ST_QWAIT;
                end
                else if (req_reg == sat_pkg::REQ_FIND && !bad_want)
                begin
                    state_next = sat_pkg::ST_SCAN;
                end
                else if (out_free)
                begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            sat_pkg::ST_QWAIT:
            begin
                if (out_free)
                begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            sat_pkg::ST_SCAN:
            begin
                if (!scan_end)
                begin
                    state_next = sat_pkg::ST_SCHK;
                end
                else if (out_free)
                begin
                    state_next = sat_pkg::ST_IDLE;
                end
            end
            sat_pkg::ST_SCHK:
            begin
                if (!entry_free)
                begin
                    state_next = sat_pkg::ST_SCAN;
                end
                else if (out_free)
                begin
                    state_next = hit_last ? sat_pkg::ST_IDLE : sat_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = sat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        emit      = 1'b0;
        result    = '0;
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_wdata = '0;
        mem_rd_en = 1'b0;
        mem_raddr = off_reg[ADDR_W-1:0];
        case (state_reg)
            sat_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            sat_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            sat_pkg::ST_EXEC:
            begin
                result.last = 1'b1;
                case (req_reg)
                    sat_pkg::REQ_QUERY:
                    begin
                        if (data_ok)
                        begin
                            mem_rd_en = 1'b1;
                            mem_raddr = data_idx[ADDR_W-1:0];
                        end
                        else
                        begin
                            emit               = out_free;
                            result.ok          = 1'b1;
                            result.status_word = in_resv ? sat_pkg::WORD_RESERVED
                                                         : sat_pkg::WORD_INVALID;
                        end
                    end
                    sat_pkg::REQ_UPDATE:
                    begin
                        emit      = out_free;
                        result.ok = data_ok;
                        mem_we    = out_free && data_ok;
                        mem_waddr = data_idx[ADDR_W-1:0];
                        mem_wdata = value_reg;
                    end
                    sat_pkg::REQ_FIND:
                    begin
                        emit = out_free && bad_want;
                    end
                    default:
                    begin
                        emit = out_free;
                    end
                endcase
            end
            sat_pkg::ST_QWAIT:
            begin
                emit               = out_free;
                result.status_word = mem_rdata;
                result.ok          = 1'b1;
                result.last        = 1'b1;
            end
            sat_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    emit        = out_free;
                    result.last = 1'b1;
                end
                else
                begin
                    mem_rd_en = 1'b1;
                end
            end
            sat_pkg::ST_SCHK:
            begin
                emit                = out_free && entry_free;
                result.found_sector = scan_sector[sat_pkg::SECTOR_W-1:0];
                result.ok           = 1'b1;
                result.last         = hit_last;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        off_next = off_reg;
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        if (state_reg == sat_pkg::ST_CLEAR)
        begin
            clr_next = clr_reg + 1'b1;
        end
        if (accept)
        begin
            off_next = '0;
            cnt_next = '0;
        end
        if (state_reg == sat_pkg::ST_SCHK)
        begin
            if (!entry_free)
            begin
                off_next = off_reg + 1'b1;
            end
            else if (out_free)
            begin
                off_next = off_reg + 1'b1;
                cnt_next = cnt_inc;
            end
        end
    end

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> out_free)
        else $error("result issued while the output register is occupied");

    a_count_below_wanted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sat_pkg::ST_SCAN || state_reg == sat_pkg::ST_SCHK)
            |-> cnt_reg < wanted_reg)
        else $error("scan continued after the requested count was met");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != sat_pkg::ST_CLEAR)
            |-> (data_ok && req_reg == sat_pkg::REQ_UPDATE))
        else $error("table written outside a valid update");

    a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sat_pkg::ST_SCHK)
            |-> ($past(state_reg) == sat_pkg::ST_SCAN
                 || $past(state_reg) == sat_pkg::ST_SCHK))
        else $error("entry checked without a preceding table read");

endmodule

>>> design/sector_allocation_table.sv
// Top level of the sector allocation table: configuration register, output register,
// and the sequencer with its status table memory.
// It depends on sat_pkg, sat_mem and sat_seq.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_data (total_sectors)
//  in       | in_valid / in_stall   | req_type, sector, new_value, wanted
//  out      | out_valid / out_stall | status_word, found_sector, ok, last
//
// After reset a clearing pass writes zero to all MAX_SECTORS entries, one per cycle,
// and in_stall stays high until the pass ends; cfg transfers are taken at once.
// A request is taken in the idle state and issued in the exec state, which loads its
// result, but a query of a data sector reads the table there and loads its result
// from the QWAIT state. A find-free request then reads each table entry in SCAN and
// checks it in SCHK, and SCAN loads the failure marker when the scan ends short.
// A result waits in the output register while out_stall is high and the sequencer holds.
module sector_allocation_table #(
    parameter int MAX_SECTORS = 4096,
    parameter int MAX_REQUEST = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sat_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [sat_pkg::REQ_W-1:0]           req_type,
    input  logic [sat_pkg::SECTOR_W-1:0]        sector,
    input  logic signed [sat_pkg::WORD_W-1:0]   new_value,
    input  logic [sat_pkg::COUNT_W-1:0]         wanted,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sat_pkg::WORD_W-1:0]   status_word,
    output logic [sat_pkg::SECTOR_W-1:0]        found_sector,
    output logic                                ok,
    output logic                                last
);

    localparam int ADDR_W = $clog2(MAX_SECTORS);
    localparam int TW     = (ADDR_W + 1 > sat_pkg::CFG_W) ? ADDR_W + 1 : sat_pkg::CFG_W;

    logic [sat_pkg::CFG_W-1:0]      total_reg;
    logic                           out_valid_reg, out_valid_next;
    sat_pkg::sat_result_t           out_reg;
    sat_pkg::sat_result_t           result;
    logic                           emit;
    logic                           out_free;

    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [sat_pkg::WORD_W-1:0]     mem_wdata;
    logic                           mem_rd_en;
    logic [ADDR_W-1:0]              mem_raddr;
    logic [sat_pkg::WORD_W-1:0]     mem_rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= sat_pkg::TOTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            total_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status_word  = out_reg.status_word;
    assign found_sector = out_reg.found_sector;
    assign ok           = out_reg.ok;
    assign last         = out_reg.last;

    sat_seq #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_REQUEST (MAX_REQUEST),
        .ADDR_W      (ADDR_W),
        .TW          (TW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .total_cfg (total_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .sector    (sector),
        .new_value (new_value),
        .wanted    (wanted),
        .out_free  (out_free),
        .emit      (emit),
        .result    (result),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_rd_en (mem_rd_en),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sat_mem #(
        .MAX_SECTORS (MAX_SECTORS),
        .ADDR_W      (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .rd_en (mem_rd_en),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
